@@ sv/mains_hum_notch_filter_top_assert.svh @@
// Assertion shorthands for the notch filter modules; only mhnf_seq uses them.
// Each expects clk and rst_n in the scope where it is used.
`ifndef MAINS_HUM_NOTCH_FILTER_TOP_ASSERT_SVH
`define MAINS_HUM_NOTCH_FILTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MHNF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MHNF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/mhnf_pkg.sv @@
`timescale 1ns / 1ps

package mhnf_pkg;

  // Default widths of the sample and of the coefficient fraction.
  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 14;

  // Delay elements and stage outputs are held in 40 bits.
  localparam int STATE_W = 40;
  localparam int HALF_W  = STATE_W / 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_SELECT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RATE_SELECT = CFG_IDX_W'(1);

  // Coefficient sets: index is {hum_select, rate_select}.
  localparam int NUM_SEL  = 4;
  localparam int SEL_W    = 2;
  localparam int NUM_COEF = 13;

  // Coefficients times 10000, per set.
  localparam int NUM_TAB [NUM_SEL][6] = '{
    '{9522, -15407, 9522, 8158, -8045, 855},
    '{5869, -11146, 5869, 10499, -20000, 10499},
    '{9528, -13891, 9528, 8272, -7225, 264},
    '{5824, -10810, 5824, 10736, -20000, 10736}
  };
  localparam int DEN_TAB [NUM_SEL][6] = '{
    '{10000, -15395, 9056, 10000, -11187, 3129},
    '{10000, -18844, 9893, 10000, -18991, 9892},
    '{10000, -13880, 9066, 10000, -9739, 2371},
    '{10000, -18407, 9894, 10000, -18584, 9891}
  };
  localparam int GAIN_TAB [NUM_SEL] = '{13422, 14399, 13430, 14206};

  // Coefficient selector: numerators, denominators, then the gain.
  typedef enum logic [3:0] {
    C_B0, C_B1, C_B2, C_B3, C_B4, C_B5,
    C_A0, C_A1, C_A2, C_A3, C_A4, C_A5,
    C_G
  } coef_sel_t;

  // Operand sources for the multiplier and for accumulator loads.
  typedef enum logic [2:0] {
    OPD_ZERO, OPD_X, OPD_Y1, OPD_Y2, OPD_S0, OPD_S1, OPD_S2, OPD_S3
  } opd_sel_t;

  // Multiplier pass: low half of the operand, or high half.
  typedef enum logic [1:0] {MUL_NONE, MUL_LO, MUL_HI} mul_op_t;

  // Product assembly and rounding.
  typedef enum logic [1:0] {RND_NONE, RND_EXACT, RND_F, RND_2F} rnd_t;

  // Accumulator operation.
  typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;

  // Saturating write of the accumulator.
  typedef enum logic [2:0] {
    DST_NONE, DST_Y1, DST_Y2, DST_S0, DST_S1, DST_S2, DST_S3, DST_OUT
  } dst_t;

  // One microcode word.
  typedef struct packed {
    mul_op_t   mul_op;
    coef_sel_t coef;
    opd_sel_t  mul_opd;
    rnd_t      rnd;
    acc_op_t   acc_op;
    opd_sel_t  ld_opd;
    dst_t      dst;
  } uop_t;

  // Sequencer to datapath control.
  typedef struct packed {
    logic take;
    logic step;
    uop_t uop;
  } ctl_t;

  localparam int PROG_LEN = 27;
  localparam int PC_W     = $clog2(PROG_LEN);
  localparam logic [PC_W-1:0] PC_LAST = PC_W'(PROG_LEN - 1);

  localparam uop_t UOP_IDLE = '{
    MUL_NONE, C_B0, OPD_ZERO, RND_NONE, ACC_NONE, OPD_ZERO, DST_NONE
  };

  // Raw coefficient (times 10000) of a set.
  function automatic int coef_raw(input int sel, input int k);
    if (k < 6) begin
      return NUM_TAB[sel][k];
    end else if (k < 12) begin
      return DEN_TAB[sel][k-6];
    end
    return GAIN_TAB[sel];
  endfunction

  // Scale by 2^frac and divide by 10000, rounding half away from zero.
  // Only evaluated at elaboration.
  function automatic longint quant(input int v, input int frac);
    longint n;
    n = longint'(v) * (longint'(1) << frac);
    if (n >= 0) begin
      return (n + 5000) / 10000;
    end
    return -((-n + 5000) / 10000);
  endfunction

  // Microprogram. Each product takes a low pass, a high pass, an assembly
  // step and an accumulate step; successive products overlap.
  function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
    uop_t u;
    u = UOP_IDLE;
    unique case (pc)
      PC_W'(0): begin
        u.mul_op = MUL_LO; u.coef = C_B0; u.mul_opd = OPD_X;
        u.acc_op = ACC_LOAD; u.ld_opd = OPD_S0;
      end
      PC_W'(1): begin
        u.mul_op = MUL_HI; u.coef = C_B0; u.mul_opd = OPD_X;
      end
      PC_W'(2): begin
        u.rnd = RND_EXACT;
        u.mul_op = MUL_LO; u.coef = C_B1; u.mul_opd = OPD_X;
      end
      PC_W'(3): begin
        u.acc_op = ACC_ADD;
        u.mul_op = MUL_HI; u.coef = C_B1; u.mul_opd = OPD_X;
      end
      PC_W'(4): begin
        u.dst = DST_Y1; u.acc_op = ACC_LOAD; u.ld_opd = OPD_S1;
        u.rnd = RND_EXACT;
      end
      PC_W'(5): begin
        u.acc_op = ACC_ADD;
        u.mul_op = MUL_LO; u.coef = C_A1; u.mul_opd = OPD_Y1;
      end
      PC_W'(6): begin
        u.mul_op = MUL_HI; u.coef = C_A1; u.mul_opd = OPD_Y1;
      end
      PC_W'(7): begin
        u.rnd = RND_F;
        u.mul_op = MUL_LO; u.coef = C_B2; u.mul_opd = OPD_X;
      end
      PC_W'(8): begin
        u.acc_op = ACC_SUB;
        u.mul_op = MUL_HI; u.coef = C_B2; u.mul_opd = OPD_X;
      end
      PC_W'(9): begin
        u.dst = DST_S0; u.acc_op = ACC_LOAD; u.ld_opd = OPD_ZERO;
        u.rnd = RND_EXACT;
        u.mul_op = MUL_LO; u.coef = C_A2; u.mul_opd = OPD_Y1;
      end
      PC_W'(10): begin
        u.acc_op = ACC_ADD;
        u.mul_op = MUL_HI; u.coef = C_A2; u.mul_opd = OPD_Y1;
      end
      PC_W'(11): begin
        u.rnd = RND_F;
        u.mul_op = MUL_LO; u.coef = C_B3; u.mul_opd = OPD_Y1;
      end
      PC_W'(12): begin
        u.acc_op = ACC_SUB;
        u.mul_op = MUL_HI; u.coef = C_B3; u.mul_opd = OPD_Y1;
      end
      PC_W'(13): begin
        u.dst = DST_S1; u.acc_op = ACC_LOAD; u.ld_opd = OPD_S2;
        u.rnd = RND_F;
        u.mul_op = MUL_LO; u.coef = C_B4; u.mul_opd = OPD_Y1;
      end
      PC_W'(14): begin
        u.acc_op = ACC_ADD;
        u.mul_op = MUL_HI; u.coef = C_B4; u.mul_opd = OPD_Y1;
      end
      PC_W'(15): begin
        u.dst = DST_Y2; u.acc_op = ACC_LOAD; u.ld_opd = OPD_S3;
        u.rnd = RND_F;
      end
      PC_W'(16): begin
        u.acc_op = ACC_ADD;
        u.mul_op = MUL_LO; u.coef = C_A4; u.mul_opd = OPD_Y2;
      end
      PC_W'(17): begin
        u.mul_op = MUL_HI; u.coef = C_A4; u.mul_opd = OPD_Y2;
      end
      PC_W'(18): begin
        u.rnd = RND_F;
        u.mul_op = MUL_LO; u.coef = C_B5; u.mul_opd = OPD_Y1;
      end
      PC_W'(19): begin
        u.acc_op = ACC_SUB;
        u.mul_op = MUL_HI; u.coef = C_B5; u.mul_opd = OPD_Y1;
      end
      PC_W'(20): begin
        u.dst = DST_S2; u.acc_op = ACC_LOAD; u.ld_opd = OPD_ZERO;
        u.rnd = RND_F;
        u.mul_op = MUL_LO; u.coef = C_A5; u.mul_opd = OPD_Y2;
      end
      PC_W'(21): begin
        u.acc_op = ACC_ADD;
        u.mul_op = MUL_HI; u.coef = C_A5; u.mul_opd = OPD_Y2;
      end
      PC_W'(22): begin
        u.rnd = RND_F;
        u.mul_op = MUL_LO; u.coef = C_G; u.mul_opd = OPD_Y2;
      end
      PC_W'(23): begin
        u.acc_op = ACC_SUB;
        u.mul_op = MUL_HI; u.coef = C_G; u.mul_opd = OPD_Y2;
      end
      PC_W'(24): begin
        u.dst = DST_S3; u.acc_op = ACC_LOAD; u.ld_opd = OPD_ZERO;
        u.rnd = RND_2F;
      end
      PC_W'(25): begin
        u.acc_op = ACC_ADD;
      end
      PC_W'(26): begin
        u.dst = DST_OUT;
      end
      default: begin
        u = UOP_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

@@ sv/mhnf_seq.sv @@
`timescale 1ns / 1ps
`include "mains_hum_notch_filter_top_assert.svh"

module mhnf_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_full,
  output mhnf_pkg::ctl_t  ctl
);
  import mhnf_pkg::*;

  logic            busy_r;
  logic            busy_nxt;
  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            take;
  logic            at_end;

  // A new word is taken whenever no sample is being worked on.
  assign in_ready = !busy_r;
  assign take     = in_valid && in_ready;
  assign at_end   = (pc_r == PC_LAST);

  // The last step writes the output register, so it waits while that is full.
  always_comb begin
    ctl.take = take;
    ctl.step = busy_r && !(at_end && out_full);
    ctl.uop  = uop_at(pc_r);
  end

  // Program counter and busy flag.
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (take) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
    end else if (ctl.step) begin
      if (at_end) begin
        busy_nxt = 1'b0;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  `MHNF_ASSERT_NEXT(a_take_starts, take, busy_r && (pc_r == '0), "sample taken but program not started")
  `MHNF_ASSERT_NOW(a_hold_only_at_end, busy_r && !ctl.step, at_end && out_full, "program held away from its last step")
  `MHNF_ASSERT_NEXT(a_end_frees, ctl.step && at_end, !busy_r, "program did not finish after its last step")

endmodule

@@ sv/mhnf_mac.sv @@
`timescale 1ns / 1ps

module mhnf_mac #(
  parameter int SAMPLE_WIDTH   = mhnf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = mhnf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mhnf_pkg::ctl_t                 ctl,
  input  logic                           hum_sel,
  input  logic                           rate_sel,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  output logic signed [SAMPLE_WIDTH-1:0] filtered
);
  import mhnf_pkg::*;

  localparam int CW    = COEF_FRAC_BITS + 2;
  localparam int MW    = CW + HALF_W + 1;
  localparam int PW    = CW + STATE_W;
  localparam int SUM_W = PW + 1;
  localparam int ACC_W = SUM_W + 2;
  localparam logic signed [SUM_W-1:0] HALF_F  = SUM_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] HALF_2F = SUM_W'(1) << (2 * COEF_FRAC_BITS - 1);

  logic signed [CW-1:0]           coef_rom [NUM_SEL][NUM_COEF];
  logic [SEL_W-1:0]               sel;
  logic signed [CW-1:0]           coef;
  logic signed [STATE_W-1:0]      mul_src;
  logic signed [STATE_W-1:0]      ld_val;
  logic signed [HALF_W:0]         mul_b;
  logic signed [MW-1:0]           mul_p;
  logic signed [SUM_W-1:0]        sum_full;
  logic signed [SUM_W-1:0]        rnd_add;

  logic signed [SAMPLE_WIDTH-1:0] x_r, x_nxt;
  logic signed [STATE_W-1:0]      x_ext;
  logic signed [MW-1:0]           lo_r, lo_nxt;
  logic signed [MW-1:0]           hi_r, hi_nxt;
  logic signed [SUM_W-1:0]        term_r, term_nxt;
  logic signed [ACC_W-1:0]        acc_r, acc_nxt;
  logic signed [STATE_W-1:0]      y1_r, y1_nxt;
  logic signed [STATE_W-1:0]      y2_r, y2_nxt;
  logic signed [STATE_W-1:0]      s0_r, s0_nxt;
  logic signed [STATE_W-1:0]      s1_r, s1_nxt;
  logic signed [STATE_W-1:0]      s2_r, s2_nxt;
  logic signed [STATE_W-1:0]      s3_r, s3_nxt;
  logic signed [STATE_W-1:0]      acc_sat;

  // Saturate the accumulator to the delay width.
  function automatic logic signed [STATE_W-1:0] sat_state(
    input logic signed [ACC_W-1:0] v
  );
    logic [ACC_W-STATE_W:0] upper;
    upper = v[ACC_W-1:STATE_W-1];
    if ((&upper) || !(|upper)) begin
      return v[STATE_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(STATE_W-1){1'b0}}};
    end
    return {1'b0, {(STATE_W-1){1'b1}}};
  endfunction

  // Saturate the accumulator to the sample width.
  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [ACC_W-1:0] v
  );
    logic [ACC_W-SAMPLE_WIDTH:0] upper;
    upper = v[ACC_W-1:SAMPLE_WIDTH-1];
    if ((&upper) || !(|upper)) begin
      return v[SAMPLE_WIDTH-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end
    return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  endfunction

  // Operand selection shared by the multiplier and the accumulator load.
  function automatic logic signed [STATE_W-1:0] pick(
    input opd_sel_t                  s,
    input logic signed [STATE_W-1:0] xv,
    input logic signed [STATE_W-1:0] y1v,
    input logic signed [STATE_W-1:0] y2v,
    input logic signed [STATE_W-1:0] s0v,
    input logic signed [STATE_W-1:0] s1v,
    input logic signed [STATE_W-1:0] s2v,
    input logic signed [STATE_W-1:0] s3v
  );
    logic signed [STATE_W-1:0] r;
    unique case (s)
      OPD_ZERO: r = '0;
      OPD_X:    r = xv;
      OPD_Y1:   r = y1v;
      OPD_Y2:   r = y2v;
      OPD_S0:   r = s0v;
      OPD_S1:   r = s1v;
      OPD_S2:   r = s2v;
      OPD_S3:   r = s3v;
    endcase
    return r;
  endfunction

  // Quantized coefficient table, built at elaboration.
  for (genvar gs = 0; gs < NUM_SEL; gs++) begin : g_sel
    for (genvar gk = 0; gk < NUM_COEF; gk++) begin : g_coef
      assign coef_rom[gs][gk] = CW'(quant(coef_raw(gs, gk), COEF_FRAC_BITS));
    end
  end

  assign sel   = {hum_sel, rate_sel};
  assign coef  = coef_rom[sel][ctl.uop.coef];
  assign x_ext = STATE_W'(x_r);

  always_comb begin
    mul_src = pick(ctl.uop.mul_opd, x_ext, y1_r, y2_r, s0_r, s1_r, s2_r, s3_r);
    ld_val  = pick(ctl.uop.ld_opd, x_ext, y1_r, y2_r, s0_r, s1_r, s2_r, s3_r);
  end

  // The one multiplier works on half the operand per pass.
  always_comb begin
    if (ctl.uop.mul_op == MUL_HI) begin
      mul_b = {mul_src[STATE_W-1], mul_src[STATE_W-1:HALF_W]};
    end else begin
      mul_b = {1'b0, mul_src[HALF_W-1:0]};
    end
  end
  assign mul_p = coef * mul_b;

  // Join the two partial products; the rounded modes add the rounding half and scale back.
  always_comb begin
    unique case (ctl.uop.rnd)
      RND_F:   rnd_add = HALF_F;
      RND_2F:  rnd_add = HALF_2F;
      default: rnd_add = '0;
    endcase
  end
  assign sum_full = SUM_W'(lo_r) + (SUM_W'(hi_r) <<< HALF_W) + rnd_add;
  assign acc_sat  = sat_state(acc_r);

  // Next values of the datapath registers; all but the input sample, which loads on take, wait for a step.
  always_comb begin
    x_nxt    = ctl.take ? in_sample : x_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    term_nxt = term_r;
    acc_nxt  = acc_r;
    y1_nxt   = y1_r;
    y2_nxt   = y2_r;
    s0_nxt   = s0_r;
    s1_nxt   = s1_r;
    s2_nxt   = s2_r;
    s3_nxt   = s3_r;
    if (ctl.step) begin
      unique case (ctl.uop.mul_op)
        MUL_LO:  lo_nxt = mul_p;
        MUL_HI:  hi_nxt = mul_p;
        default: ;
      endcase
      unique case (ctl.uop.rnd)
        RND_EXACT: term_nxt = sum_full;
        RND_F:     term_nxt = sum_full >>> COEF_FRAC_BITS;
        RND_2F:    term_nxt = sum_full >>> (2 * COEF_FRAC_BITS);
        default:   ;
      endcase
      unique case (ctl.uop.acc_op)
        ACC_LOAD: acc_nxt = ACC_W'(ld_val);
        ACC_ADD:  acc_nxt = acc_r + ACC_W'(term_r);
        ACC_SUB:  acc_nxt = acc_r - ACC_W'(term_r);
        default:  ;
      endcase
      unique case (ctl.uop.dst)
        DST_Y1:  y1_nxt = acc_sat;
        DST_Y2:  y2_nxt = acc_sat;
        DST_S0:  s0_nxt = acc_sat;
        DST_S1:  s1_nxt = acc_sat;
        DST_S2:  s2_nxt = acc_sat;
        DST_S3:  s3_nxt = acc_sat;
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    term_r <= term_nxt;
    acc_r  <= acc_nxt;
    y1_r   <= y1_nxt;
    y2_r   <= y2_nxt;
  end

  // Filter delays clear at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r <= '0;
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
    end else begin
      s0_r <= s0_nxt;
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  assign filtered = sat_sample(acc_r);

endmodule

@@ sv/mains_hum_notch_filter_top.sv @@
`timescale 1ns / 1ps

// Mains hum notch filter: each input word is one signed sample, each output
// word the sample with 50 Hz or 60 Hz hum removed by two cascaded biquad
// sections and a gain, saturated to the sample width. Register 0 picks the
// hum frequency (0 = 50 Hz, 1 = 60 Hz) and register 1 the sample rate
// (0 = 500 Hz, 1 = 1000 Hz); write them only while no sample is in flight.
// Each sample runs through the whole microprogram before a valid output
// word appears, and a new sample is taken only once the last is done, so
// the block does not overlap samples. The single 21-bit-operand multiplier,
// which needs two passes for each of the eleven products, sets the pace. The
// output register lets the next sample start while a result waits; if it
// is still unread when the next result is due, the block holds.

module mains_hum_notch_filter_top #(
  parameter int SAMPLE_WIDTH   = mhnf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = mhnf_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      out_filtered,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mhnf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mhnf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mhnf_pkg::*;

  ctl_t                           ctl;
  logic                           hum_r, hum_nxt;
  logic                           rate_r, rate_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_filtered_r, out_filtered_nxt;
  logic signed [SAMPLE_WIDTH-1:0] filtered;
  logic                           out_full;
  logic                           out_load;

  mhnf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_full (out_full),
    .ctl      (ctl)
  );

  mhnf_mac #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .hum_sel   (hum_r),
    .rate_sel  (rate_r),
    .in_sample (in_sample),
    .filtered  (filtered)
  );

  // Configuration writes; unknown indexes and upper data bits are ignored.
  assign cfg_ready = 1'b1;

  always_comb begin
    hum_nxt  = hum_r;
    rate_nxt = rate_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HUM_SELECT:  hum_nxt  = cfg_data[0];
        REG_RATE_SELECT: rate_nxt = cfg_data[0];
        default:         ;
      endcase
    end
  end

  // Output register: filled by the last program step, emptied by the sink.
  assign out_full = out_valid_r && !out_ready;
  assign out_load = ctl.step && (ctl.uop.dst == DST_OUT);

  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_filtered_nxt = out_filtered_r;
    if (out_load) begin
      out_valid_nxt    = 1'b1;
      out_filtered_nxt = filtered;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hum_r       <= 1'b0;
      rate_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hum_r       <= hum_nxt;
      rate_r      <= rate_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_filtered_r <= out_filtered_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  import mhnf_pkg::*;

  localparam int SW   = SAMPLE_WIDTH_DEF;
  localparam int FRAC = COEF_FRAC_BITS_DEF;

  // Shapes of the random sample streams.
  typedef enum logic [1:0] {WAVE_NOISE, WAVE_QUIET, WAVE_SQUARE, WAVE_RAIL} wave_t;

  // Bit-exact model of the two biquad stages plus the gain, with a queue of
  // the output words still owed by the block.
  class hum_filter_scoreboard;
    int                 coef_x10k[4][13];
    bit                 hum_sel;
    bit                 rate_sel;
    longint             dly[4];
    logic signed [SW-1:0] filtered_q[$];
    int                 errors;

    function new();
      // Per set {hum, rate}: b0..b5, a0..a5, then the gain, all times 10000.
      coef_x10k = '{
        '{9522, -15407, 9522, 8158, -8045, 855,
          10000, -15395, 9056, 10000, -11187, 3129, 13422},
        '{5869, -11146, 5869, 10499, -20000, 10499,
          10000, -18844, 9893, 10000, -18991, 9892, 14399},
        '{9528, -13891, 9528, 8272, -7225, 264,
          10000, -13880, 9066, 10000, -9739, 2371, 13430},
        '{5824, -10810, 5824, 10736, -20000, 10736,
          10000, -18407, 9894, 10000, -18584, 9891, 14206}};
      hum_sel  = 1'b0;
      rate_sel = 1'b0;
      errors   = 0;
      foreach (dly[i]) dly[i] = 0;
    endfunction

    // Coefficient k of the current set in Q2.FRAC, rounded half away from zero.
    function longint coef_fixed(int k);
      longint n;
      n = longint'(coef_x10k[hum_sel * 2 + rate_sel][k]) * (longint'(1) << FRAC);
      if (n >= 0) begin
        return (n + 5000) / 10000;
      end
      return -((-n + 5000) / 10000);
    endfunction

    function longint clamp(longint v, int w);
      longint hi;
      longint lo;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        return hi;
      end
      if (v < lo) begin
        return lo;
      end
      return v;
    endfunction

    // Coefficient times a stage output, rounded back to FRAC fraction bits.
    function longint mul_round(longint c, longint y);
      return (c * y + (longint'(1) << (FRAC - 1))) >>> FRAC;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) begin
        $display("testbench: error at %0t: %s", $time, msg);
      end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_HUM_SELECT) begin
        hum_sel = data[0];
      end else if (idx == REG_RATE_SELECT) begin
        rate_sel = data[0];
      end
    endfunction

    // Run one accepted input word through the filter and queue its output.
    function void note_sample(logic signed [SW-1:0] x);
      longint xs;
      longint b[6];
      longint a[6];
      longint g;
      longint y1;
      longint y2;
      longint o;
      logic signed [SW-1:0] word;
      xs = x;
      for (int k = 0; k < 6; k++) begin
        b[k] = coef_fixed(k);
        a[k] = coef_fixed(k + 6);
      end
      g = coef_fixed(12);

      y1     = clamp(b[0] * xs + dly[0], STATE_W);
      dly[0] = clamp(b[1] * xs + dly[1] - mul_round(a[1], y1), STATE_W);
      dly[1] = clamp(b[2] * xs - mul_round(a[2], y1), STATE_W);

      y2     = clamp(mul_round(b[3], y1) + dly[2], STATE_W);
      dly[2] = clamp(mul_round(b[4], y1) + dly[3] - mul_round(a[4], y2), STATE_W);
      dly[3] = clamp(mul_round(b[5], y1) - mul_round(a[5], y2), STATE_W);

      o    = clamp((g * y2 + (longint'(1) << (2 * FRAC - 1))) >>> (2 * FRAC), SW);
      word = SW'(o);
      filtered_q.push_back(word);
    endfunction

    function void check_result(logic signed [SW-1:0] got);
      logic signed [SW-1:0] want;
      if (filtered_q.size() == 0) begin
        flag($sformatf("output word %0d with nothing expected", got));
        return;
      end
      want = filtered_q.pop_front();
      if (got !== want) begin
        flag($sformatf("filtered expected %0d, got %0d", want, got));
      end
    endfunction

    function int pending();
      return filtered_q.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic signed [SW-1:0]   in_sample;
  logic                   out_valid;
  logic                   out_ready;
  logic signed [SW-1:0]   out_filtered;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 1'b0;
  int hold_left      = 0;

  hum_filter_scoreboard sb = new();

  mains_hum_notch_filter_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_filtered (out_filtered),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Every handshake is seen here, on values from before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_result(out_filtered);
      end
      if (in_valid && in_ready) begin
        sb.note_sample(in_sample);
      end
      if (cfg_valid && cfg_ready) begin
        sb.set_register(cfg_index, cfg_data);
      end
    end
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = 300;
        out_ready   <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Valid stays high after acceptance; the caller lowers it when it pauses.
  task automatic send_sample(logic signed [SW-1:0] x);
    in_valid  <= 1'b1;
    in_sample <= x;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Stop offering words and wait until every owed output word is back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Sender gap: mostly short runs, sometimes long enough to land anywhere
  // in the block's processing of a word.
  task automatic idle_before_word();
    int n;
    if (send_idle_pct > 0) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
      while ($urandom_range(0, 99) < send_idle_pct) n++;
      if (n > 0) begin
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  endtask

  initial begin
    #5000000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    logic [1:0]            sel;
    logic [CFG_DATA_W-1:0] data;
    logic signed [SW-1:0]  x;
    wave_t                 wave;
    int                    amp;
    int                    half;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_sample <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Writes to unused indexes must leave the 50 Hz / 500 Hz default alone.
    cfg_write(CFG_IDX_W'(15), 8'hFF);
    cfg_write(CFG_IDX_W'(2), 8'hFF);
    cfg_valid <= 1'b0;

    // Directed: field extremes, then full-scale swings and steps that drive
    // the stages and the output into saturation.
    send_sample(16'sd0);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    for (int i = 0; i < 8; i++) begin
      send_sample(i[0] ? -16'sd32768 : 16'sd32767);
    end
    for (int i = 0; i < 4; i++) begin
      send_sample(16'sd32767);
    end
    for (int i = 0; i < 3; i++) begin
      send_sample(-16'sd32768);
    end

    // Random phases: each coefficient set, each idling mode; the filter
    // state carries over from one setting to the next.
    for (int phase = 0; phase < 8; phase++) begin
      sel = 2'((phase + phase / 4) % 4);
      drain();
      cfg_write(CFG_IDX_W'($urandom_range(2, 15)), CFG_DATA_W'($urandom_range(0, 255)));
      data    = CFG_DATA_W'($urandom_range(0, 255));
      data[0] = sel[1];
      cfg_write(REG_HUM_SELECT, data);
      data    = CFG_DATA_W'($urandom_range(0, 255));
      data[0] = sel[0];
      cfg_write(REG_RATE_SELECT, data);
      cfg_valid <= 1'b0;

      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 69;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 69;
        end
        default: begin
          send_idle_pct  = 16;
          recv_stall_pct = 16;
        end
      endcase

      for (int n = 0; n < 60; n++) begin
        if (n % 12 == 0) begin
          wave = wave_t'($urandom_range(0, 3));
          amp  = $urandom_range(0, 32767);
          half = $urandom_range(1, 6);
        end
        // Long output hold-off while words keep coming, so the block backs up.
        if (phase == 0 && n == 10) begin
          hold_request = 1'b1;
        end
        case (wave)
          WAVE_NOISE:  x = SW'($urandom_range(0, 65535));
          WAVE_QUIET:  x = SW'(int'($urandom_range(0, 1023)) - 512);
          WAVE_SQUARE: x = ((n / half) % 2 != 0) ? SW'(amp)
                                                 : SW'(-amp - int'($urandom_range(0, 1)));
          default:     x = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
        endcase
        idle_before_word();
        send_sample(x);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.flag($sformatf("%0d expected output words never arrived", sb.pending()));
    end
    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
